// File: src/bds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pkg
// Shared widths, codes and payload types of the box-filter downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

    // fixed field widths
    localparam int PIX_W          = 8;
    localparam int PCOL_W         = 8;
    localparam int PROW_W         = 10;
    localparam int OUT_W_W        = 9;
    localparam int OUT_H_W        = 11;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int MAX_OUT_HEIGHT = 1024;

    // queue depths
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_WIDTH  = 1'b0,
        CFG_OUT_HEIGHT = 1'b1
    } t_cfg_idx;

    // control part of a sub-row transaction from front to back
    typedef struct packed {
        logic              first;
        logic              emit;
        logic              last;
        logic [PCOL_W-1:0] pixel_column;
        logic [PROW_W-1:0] pixel_row;
    } t_cmd_ctl;

    // one output pixel
    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic [PCOL_W-1:0] pixel_column;
        logic [PROW_W-1:0] pixel_row;
        logic              frame_last;
    } t_pixel;

endpackage
`default_nettype wire

// File: src/bds_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_in_if
// Input pixel channel: valid/ready handshake with one RGB pixel.
// ----------------------------------------------------------------------------
interface bds_in_if;
    import bds_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface
`default_nettype wire

// File: src/bds_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_out_if
// Output pixel channel: valid/ready handshake with one averaged pixel.
// ----------------------------------------------------------------------------
interface bds_out_if;
    import bds_pkg::*;

    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  out_red;
    logic [PIX_W-1:0]  out_green;
    logic [PIX_W-1:0]  out_blue;
    logic [PCOL_W-1:0] pixel_column;
    logic [PROW_W-1:0] pixel_row;
    logic              frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output pixel_column, output pixel_row, output frame_last,
                    input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input pixel_column, input pixel_row, input frame_last,
                    output ready);
endinterface
`default_nettype wire

// File: src/box_downsample_4x4_rgb_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_downsample_4x4_rgb_unit
// Box-filter downsampler: averages each FACTOR x FACTOR block of an RGB
// raster image into one output pixel with its column, row and frame end flag.
// ----------------------------------------------------------------------------
// The block takes one input pixel per clock in raster order for as long as
// its four-entry transaction queue has room, and gives one result per
// FACTOR*FACTOR input pixels, passed through the b1, b2 and b3 registers
// and into the four-entry output queue. The front end updates the horizontal
// sums and position counters in the accepting cycle; every FACTOR pixels it
// passes one sub-row transaction to the back end, which does a single
// read-modify-write of the row store (one read and one write port, with a
// bypass of the previous write) and a pipelined reciprocal multiply. Input is
// stalled only when the output side is held back long enough to fill both
// queues. The row store needs no clearing after reset. out_width and
// out_height are to be written only while no frame is in progress.
module box_downsample_4x4_rgb_unit #(
    parameter int FACTOR        = 4,
    parameter int MAX_OUT_WIDTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire bds_pkg::t_cfg_idx             i_cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bds_in_if.sink                             i_pix,
    bds_out_if.source                          o_pix
);
    import bds_pkg::*;

    localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int SUM_W = $clog2(FACTOR * FACTOR * 255 + 1);
    localparam int CMD_W = $bits(t_cmd_ctl) + COL_W + 3 * SUM_W;

    logic                  w_cmd_push;
    logic                  w_cmd_full;
    logic                  w_cmd_empty;
    logic                  w_cmd_pop;
    t_cmd_ctl              w_cmd_ctl;
    logic [COL_W-1:0]      w_cmd_idx;
    logic [2:0][SUM_W-1:0] w_cmd_sum;
    logic [CMD_W-1:0]      w_cmd_push_data;
    logic [CMD_W-1:0]      w_cmd_pop_data;
    t_cmd_ctl              w_q_ctl;
    logic [COL_W-1:0]      w_q_idx;
    logic [2:0][SUM_W-1:0] w_q_sum;

    // pixel intake and classification
    bds_front #(
        .FACTOR        (FACTOR),
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .i_cmd_full  (w_cmd_full),
        .o_cmd_push  (w_cmd_push),
        .o_cmd_ctl   (w_cmd_ctl),
        .o_cmd_idx   (w_cmd_idx),
        .o_cmd_sum   (w_cmd_sum)
    );

    // transaction queue between front and back
    assign w_cmd_push_data             = {w_cmd_ctl, w_cmd_idx, w_cmd_sum};
    assign {w_q_ctl, w_q_idx, w_q_sum} = w_cmd_pop_data;

    bds_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_cmd_push),
        .i_push_data (w_cmd_push_data),
        .i_pop       (w_cmd_pop),
        .o_pop_data  (w_cmd_pop_data),
        .o_full      (w_cmd_full),
        .o_empty     (w_cmd_empty),
        .o_count     ()
    );

    // column accumulation, averaging and result delivery
    bds_back #(
        .FACTOR        (FACTOR),
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_cmd_empty),
        .i_cmd_ctl   (w_q_ctl),
        .i_cmd_idx   (w_q_idx),
        .i_cmd_sum   (w_q_sum),
        .o_cmd_pop   (w_cmd_pop),
        .o_pix       (o_pix)
    );

endmodule
`default_nettype wire

// File: src/bds_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_fifo
// Small register-based first-in first-out queue with occupancy count.
// ----------------------------------------------------------------------------
module bds_fifo #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 4,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_pop_data,
    output logic                  o_full,
    output logic                  o_empty,
    output logic      [CNT_W-1:0] o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data = r_mem[r_rd_ptr];
    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_count    = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("fifo pushed while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("fifo popped while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (o_count == $past(o_count) + CNT_W'(1)))
        else $error("fifo count did not follow a push");
`endif
endmodule
`default_nettype wire

// File: src/bds_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_front
// Accepts raster pixels, keeps the position counters and the horizontal
// sums, and issues one sub-row transaction per completed sub-row segment.
// ----------------------------------------------------------------------------
module bds_front #(
    parameter int  FACTOR        = 4,
    parameter int  MAX_OUT_WIDTH = 256,
    localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1,
    localparam int SUM_W = $clog2(FACTOR * FACTOR * 255 + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire bds_pkg::t_cfg_idx             i_cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bds_in_if.sink                             i_pix,
    input  wire logic                          i_cmd_full,
    output logic                               o_cmd_push,
    output bds_pkg::t_cmd_ctl                  o_cmd_ctl,
    output logic      [COL_W-1:0]              o_cmd_idx,
    output logic      [2:0][SUM_W-1:0]         o_cmd_sum
);
    import bds_pkg::*;

    localparam int SUB_W  = $clog2(FACTOR);
    localparam int RUN_W  = $clog2(FACTOR * 255 + 1);
    localparam int WCMP_W = ($clog2(MAX_OUT_WIDTH + 1) > OUT_W_W) ?
                            $clog2(MAX_OUT_WIDTH + 1) : OUT_W_W;
    localparam logic [SUB_W-1:0]   SUB_LAST = SUB_W'(FACTOR - 1);
    localparam logic [WCMP_W-1:0]  W_MAX    = WCMP_W'(MAX_OUT_WIDTH);
    localparam logic [OUT_H_W-1:0] H_MAX    = OUT_H_W'(MAX_OUT_HEIGHT);

    logic [OUT_W_W-1:0]      r_out_width;
    logic [OUT_H_W-1:0]      r_out_height;
    logic [2:0][RUN_W-1:0]   r_run,          n_run;
    logic [SUB_W-1:0]        r_sub_column,   n_sub_column;
    logic [SUB_W-1:0]        r_sub_row,      n_sub_row;
    logic [COL_W-1:0]        r_block_column, n_block_column;
    logic [PROW_W-1:0]       r_block_row,    n_block_row;

    logic                    w_accept;
    logic [2:0][PIX_W-1:0]   w_in;
    logic [2:0][RUN_W-1:0]   w_sum;
    logic [WCMP_W-1:0]       w_width_ext;
    logic [WCMP_W-1:0]       w_width_eff;
    logic [OUT_H_W-1:0]      w_height_eff;
    logic                    w_col_wrap;
    logic                    w_row_last;
    logic                    w_bcol_last;
    logic                    w_brow_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= OUT_W_W'(1);
            r_out_height <= OUT_H_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data[OUT_W_W-1:0];
                CFG_OUT_HEIGHT: r_out_height <= i_cfg_data[OUT_H_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamped image size
    assign w_width_ext  = WCMP_W'(r_out_width);
    assign w_width_eff  = (r_out_width == '0) ? WCMP_W'(1) :
                          (w_width_ext > W_MAX) ? W_MAX : w_width_ext;
    assign w_height_eff = (r_out_height == '0) ? OUT_H_W'(1) :
                          (r_out_height > H_MAX) ? H_MAX : r_out_height;

    // position classification
    assign w_col_wrap  = (r_sub_column == SUB_LAST);
    assign w_row_last  = (r_sub_row == SUB_LAST);
    assign w_bcol_last = (WCMP_W'(r_block_column) + WCMP_W'(1)) >= w_width_eff;
    assign w_brow_last = ({1'b0, r_block_row} + OUT_H_W'(1)) >= w_height_eff;

    assign i_pix.ready = !i_cmd_full;
    assign w_accept    = i_pix.valid && i_pix.ready;

    // horizontal sums including the current pixel
    always_comb begin
        w_in[0] = i_pix.in_red;
        w_in[1] = i_pix.in_green;
        w_in[2] = i_pix.in_blue;
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = r_run[c] + RUN_W'(w_in[c]);
        end
    end

    // counter and running sum update
    always_comb begin
        n_run          = r_run;
        n_sub_column   = r_sub_column;
        n_sub_row      = r_sub_row;
        n_block_column = r_block_column;
        n_block_row    = r_block_row;
        if (w_accept) begin
            if (w_col_wrap) begin
                n_run        = '0;
                n_sub_column = '0;
                if (w_bcol_last) begin
                    n_block_column = '0;
                    if (w_row_last) begin
                        n_sub_row   = '0;
                        n_block_row = w_brow_last ? '0 : r_block_row + PROW_W'(1);
                    end else begin
                        n_sub_row = r_sub_row + SUB_W'(1);
                    end
                end else begin
                    n_block_column = r_block_column + COL_W'(1);
                end
            end else begin
                n_run        = w_sum;
                n_sub_column = r_sub_column + SUB_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run          <= '0;
            r_sub_column   <= '0;
            r_sub_row      <= '0;
            r_block_column <= '0;
            r_block_row    <= '0;
        end else begin
            r_run          <= n_run;
            r_sub_column   <= n_sub_column;
            r_sub_row      <= n_sub_row;
            r_block_column <= n_block_column;
            r_block_row    <= n_block_row;
        end
    end

    // sub-row transaction towards the back end
    always_comb begin
        o_cmd_push             = w_accept && w_col_wrap;
        o_cmd_idx              = r_block_column;
        o_cmd_ctl.first        = (r_sub_row == '0);
        o_cmd_ctl.emit         = w_row_last;
        o_cmd_ctl.last         = w_row_last && w_bcol_last && w_brow_last;
        o_cmd_ctl.pixel_column = PCOL_W'(r_block_column);
        o_cmd_ctl.pixel_row    = r_block_row;
        for (int c = 0; c < 3; c++) begin
            o_cmd_sum[c] = SUM_W'(w_sum[c]);
        end
    end

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_cmd_full)
        else $error("sub-row transaction issued into a full queue");
    a_last_is_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_push && o_cmd_ctl.last) |-> o_cmd_ctl.emit)
        else $error("frame end flagged on a non-final sub-row");
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_push && o_cmd_ctl.last) |=>
            (r_block_row == '0 && r_block_column == '0 && r_sub_row == '0))
        else $error("counters did not wrap after the final block");
`endif
endmodule
`default_nettype wire

// File: src/bds_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_back
// Row store read-modify-write of column sums, block average by reciprocal
// multiply, and the output queue.
// ----------------------------------------------------------------------------
module bds_back #(
    parameter int  FACTOR        = 4,
    parameter int  MAX_OUT_WIDTH = 256,
    localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1,
    localparam int SUM_W = $clog2(FACTOR * FACTOR * 255 + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    input  wire bds_pkg::t_cmd_ctl     i_cmd_ctl,
    input  wire logic [COL_W-1:0]      i_cmd_idx,
    input  wire logic [2:0][SUM_W-1:0] i_cmd_sum,
    output logic                       o_cmd_pop,
    bds_out_if.source                  o_pix
);
    import bds_pkg::*;

    // floor(n / DIV) = (n * RECIP) >> DIV_SHIFT for every n below 2**SUM_W
    localparam int DIV       = FACTOR * FACTOR;
    localparam int DIV_SHIFT = SUM_W + $clog2(DIV);
    localparam int RECIP_W   = SUM_W + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** DIV_SHIFT + DIV - 1) / DIV);
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
    localparam int CRD_W     = $clog2(OUT_DEPTH + 4);
    localparam int PIXEL_W   = $bits(t_pixel);

    logic [2:0][SUM_W-1:0]  r_mem [MAX_OUT_WIDTH];

    logic                   r_b1_valid;
    t_cmd_ctl               r_b1_ctl;
    logic [COL_W-1:0]       r_b1_idx;
    logic [2:0][SUM_W-1:0]  r_b1_sum;
    logic [2:0][SUM_W-1:0]  r_rd_data;

    logic                   r_fwd_valid;
    logic [COL_W-1:0]       r_fwd_idx;
    logic [2:0][SUM_W-1:0]  r_fwd_data;

    logic                   r_b2_valid;
    t_cmd_ctl               r_b2_ctl;
    logic [2:0][SUM_W-1:0]  r_b2_acc;

    logic                   r_b3_valid;
    t_cmd_ctl               r_b3_ctl;
    logic [2:0][PROD_W-1:0] r_b3_prod;

    logic [2:0][SUM_W-1:0]  w_old;
    logic [2:0][SUM_W-1:0]  w_acc;
    logic [CRD_W-1:0]       w_in_flight;
    logic [CNT_W-1:0]       w_out_count;
    logic                   w_out_empty;
    logic                   w_out_pop;
    t_pixel                 w_out_push_data;
    t_pixel                 w_out_head;

    // issue only when the output queue can take every result in flight
    assign w_in_flight = CRD_W'(r_b1_valid && r_b1_ctl.emit) + CRD_W'(r_b2_valid) +
                         CRD_W'(r_b3_valid) + CRD_W'(w_out_count);
    assign o_cmd_pop   = i_cmd_valid && (w_in_flight < CRD_W'(OUT_DEPTH));

    // row store: registered read at issue, write of the new column sum
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_rd_data <= r_mem[i_cmd_idx];
        end
        if (r_b1_valid) begin
            r_mem[r_b1_idx] <= w_acc;
        end
    end

    // column accumulate with bypass of the write from the previous cycle
    always_comb begin
        w_old = (r_fwd_valid && r_fwd_idx == r_b1_idx) ? r_fwd_data : r_rd_data;
        for (int c = 0; c < 3; c++) begin
            w_acc[c] = r_b1_sum[c] + (r_b1_ctl.first ? '0 : w_old[c]);
        end
    end

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
        end else begin
            r_b1_valid  <= o_cmd_pop;
            r_fwd_valid <= r_b1_valid;
            r_b2_valid  <= r_b1_valid && r_b1_ctl.emit;
            r_b3_valid  <= r_b2_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_b1_ctl <= i_cmd_ctl;
            r_b1_idx <= i_cmd_idx;
            r_b1_sum <= i_cmd_sum;
        end
        r_fwd_idx  <= r_b1_idx;
        r_fwd_data <= w_acc;
        r_b2_ctl   <= r_b1_ctl;
        r_b2_acc   <= w_acc;
        r_b3_ctl   <= r_b2_ctl;
        for (int c = 0; c < 3; c++) begin
            r_b3_prod[c] <= PROD_W'(r_b2_acc[c]) * PROD_W'(RECIP);
        end
    end

    // quotient is the top part of the product
    always_comb begin
        w_out_push_data.red          = PIX_W'(r_b3_prod[0] >> DIV_SHIFT);
        w_out_push_data.green        = PIX_W'(r_b3_prod[1] >> DIV_SHIFT);
        w_out_push_data.blue         = PIX_W'(r_b3_prod[2] >> DIV_SHIFT);
        w_out_push_data.pixel_column = r_b3_ctl.pixel_column;
        w_out_push_data.pixel_row    = r_b3_ctl.pixel_row;
        w_out_push_data.frame_last   = r_b3_ctl.last;
    end

    // output queue
    bds_fifo #(
        .WIDTH (PIXEL_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_b3_valid),
        .i_push_data (w_out_push_data),
        .i_pop       (w_out_pop),
        .o_pop_data  (w_out_head),
        .o_full      (),
        .o_empty     (w_out_empty),
        .o_count     (w_out_count)
    );

    assign o_pix.valid        = !w_out_empty;
    assign w_out_pop          = o_pix.valid && o_pix.ready;
    assign o_pix.out_red      = w_out_head.red;
    assign o_pix.out_green    = w_out_head.green;
    assign o_pix.out_blue     = w_out_head.blue;
    assign o_pix.pixel_column = w_out_head.pixel_column;
    assign o_pix.pixel_row    = w_out_head.pixel_row;
    assign o_pix.frame_last   = w_out_head.frame_last;

`ifndef SYNTHESIS
    a_out_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b3_valid |-> (w_out_count < CNT_W'(OUT_DEPTH)))
        else $error("result reached a full output queue");
    a_no_emit_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b1_valid && !r_b1_ctl.emit) |=> !r_b2_valid)
        else $error("result produced from a non-final sub-row");
    a_stage_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b2_valid |=> r_b3_valid)
        else $error("result lost between accumulate and multiply stages");
`endif
endmodule
`default_nettype wire

// File: test/bds_pixel_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pixel_checker
// Watches the configuration port and both pixel channels of the box-filter
// downsampler, keeps its own copy of the block sums and position counters,
// predicts each averaged output pixel and compares every output transaction
// against the oldest prediction. Mismatches and unexpected outputs are
// counted; the count and the number of outstanding predictions go to the top.
// ----------------------------------------------------------------------------
module bds_pixel_checker #(
    parameter int FACTOR        = 4,
    parameter int MAX_OUT_WIDTH = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire bds_pkg::t_cfg_idx              i_cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bds_in_if                                   i_pix,
    bds_out_if                                  i_avg,
    output int unsigned                         o_mismatches,
    output int unsigned                         o_outstanding
);
    import bds_pkg::*;

    localparam int BLOCK_AREA = FACTOR * FACTOR;

    // mirrored geometry registers
    logic [OUT_W_W-1:0] width_reg;
    logic [OUT_H_W-1:0] height_reg;

    // running sums along one sub-row and partial column sums per output column
    int unsigned run_red, run_green, run_blue;
    int unsigned col_red   [MAX_OUT_WIDTH];
    int unsigned col_green [MAX_OUT_WIDTH];
    int unsigned col_blue  [MAX_OUT_WIDTH];

    // position within the input raster
    int unsigned sub_col, blk_col, sub_row, blk_row;

    t_pixel      expected_pixels [$];
    int unsigned mismatch_total;

    // fold one accepted input pixel into the sums, queue an output on block end
    task automatic accumulate_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                                    input logic [PIX_W-1:0] blue);
        int unsigned eff_w, eff_h;
        int unsigned acc_r, acc_g, acc_b;
        t_pixel      px;
        eff_w = (width_reg == 0) ? 1 :
                (width_reg > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : int'(width_reg);
        eff_h = (height_reg == 0) ? 1 :
                (height_reg > MAX_OUT_HEIGHT) ? MAX_OUT_HEIGHT : int'(height_reg);
        run_red   += red;
        run_green += green;
        run_blue  += blue;
        if (sub_col + 1 >= FACTOR) begin
            acc_r = run_red;
            acc_g = run_green;
            acc_b = run_blue;
            // later sub-rows add onto the column entry written by the first one
            if (sub_row != 0) begin
                acc_r += col_red[blk_col];
                acc_g += col_green[blk_col];
                acc_b += col_blue[blk_col];
            end
            col_red[blk_col]   = acc_r;
            col_green[blk_col] = acc_g;
            col_blue[blk_col]  = acc_b;
            run_red   = 0;
            run_green = 0;
            run_blue  = 0;
            if (sub_row + 1 >= FACTOR) begin
                px.red          = PIX_W'(acc_r / BLOCK_AREA);
                px.green        = PIX_W'(acc_g / BLOCK_AREA);
                px.blue         = PIX_W'(acc_b / BLOCK_AREA);
                px.pixel_column = PCOL_W'(blk_col);
                px.pixel_row    = PROW_W'(blk_row);
                px.frame_last   = (blk_col + 1 >= eff_w) && (blk_row + 1 >= eff_h);
                expected_pixels.push_back(px);
            end
            // advance counters, each wrapping at its effective limit
            sub_col = 0;
            if (blk_col + 1 >= eff_w) begin
                blk_col = 0;
                if (sub_row + 1 >= FACTOR) begin
                    sub_row = 0;
                    blk_row = (blk_row + 1 >= eff_h) ? 0 : blk_row + 1;
                end else begin
                    sub_row++;
                end
            end else begin
                blk_col++;
            end
        end else begin
            sub_col++;
        end
    endtask

    // sample configuration and channel transactions at each edge
    always @(posedge i_clk) begin : watch
        t_pixel seen;
        t_pixel want;
        if (!i_rst_n) begin
            width_reg  = OUT_W_W'(1);
            height_reg = OUT_H_W'(1);
            run_red    = 0;
            run_green  = 0;
            run_blue   = 0;
            col_red    = '{default: 0};
            col_green  = '{default: 0};
            col_blue   = '{default: 0};
            sub_col    = 0;
            blk_col    = 0;
            sub_row    = 0;
            blk_row    = 0;
            mismatch_total = 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OUT_WIDTH:  width_reg  = i_cfg_data[OUT_W_W-1:0];
                    CFG_OUT_HEIGHT: height_reg = i_cfg_data[OUT_H_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                accumulate_pixel(i_pix.in_red, i_pix.in_green, i_pix.in_blue);
            end
            if (i_avg.valid && i_avg.ready) begin
                seen.red          = i_avg.out_red;
                seen.green        = i_avg.out_green;
                seen.blue         = i_avg.out_blue;
                seen.pixel_column = i_avg.pixel_column;
                seen.pixel_row    = i_avg.pixel_row;
                seen.frame_last   = i_avg.frame_last;
                if (expected_pixels.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10) begin
                        $display("%0t: unexpected output transaction, expected none",
                                 $realtime);
                        $display("    actual r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b",
                                 seen.red, seen.green, seen.blue,
                                 seen.pixel_column, seen.pixel_row, seen.frame_last);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (seen.red !== want.red || seen.green !== want.green ||
                        seen.blue !== want.blue || seen.pixel_column !== want.pixel_column ||
                        seen.pixel_row !== want.pixel_row ||
                        seen.frame_last !== want.frame_last) begin
                        mismatch_total++;
                        if (mismatch_total <= 10) begin
                            $display("%0t: output mismatch", $realtime);
                            $display("    expected r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b",
                                     want.red, want.green, want.blue,
                                     want.pixel_column, want.pixel_row, want.frame_last);
                            $display("    actual   r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b",
                                     seen.red, seen.green, seen.blue,
                                     seen.pixel_column, seen.pixel_row, seen.frame_last);
                        end
                    end
                end
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= expected_pixels.size();
    end

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the box-filter downsampler.
// ----------------------------------------------------------------------------
// Feeds whole frames of random RGB pixels under a series of image geometries,
// including zero register values that clamp to one and width data whose upper
// bits are dropped. Geometry is only changed between frames once every
// predicted output has arrived. Both channels idle at random, with some
// stretches at full rate. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import bds_pkg::*;

    localparam int FACTOR        = 4;
    localparam int MAX_OUT_WIDTH = 256;
    localparam int CLK_PERIOD    = 12;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 920;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bds_in_if  pix_in ();
    bds_out_if pix_out ();

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned items_sent;
    int unsigned pause_mark;
    int unsigned rx_hold;
    bit          tx_steady;
    bit          rx_steady;

    box_downsample_4x4_rgb_unit #(
        .FACTOR        (FACTOR),
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_in),
        .o_pix       (pix_out)
    );

    bds_pixel_checker #(
        .FACTOR        (FACTOR),
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_pix         (pix_in),
        .i_avg         (pix_out),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    // output side: ready is held low at random before each output transaction, unless in steady mode
    initial begin
        pix_out.ready = 1'b0;
        rx_hold       = $urandom_range(0, 6);
        forever begin
            @(posedge i_clk);
            if (pix_out.valid && pix_out.ready) begin
                rx_hold = rx_steady ? 0 : $urandom_range(0, 6);
            end else if (pix_out.valid && rx_hold > 0) begin
                rx_hold--;
            end
            pix_out.ready <= (rx_hold == 0);
        end
    end

    // one input transaction, optionally after waiting for all outputs to drain
    task automatic send_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                              input logic [PIX_W-1:0] blue, input bit drain_first);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (drain_first) begin
            pix_in.valid <= 1'b0;
            do @(posedge i_clk); while (outstanding != 0);
        end
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.in_red   <= red;
        pix_in.in_green <= green;
        pix_in.in_blue  <= blue;
        do @(posedge i_clk); while (!pix_in.ready);
        items_sent++;
    endtask

    // stop sending and let every predicted output arrive
    task automatic settle();
        pix_in.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx index, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // set the geometry, then send whole frames of random pixels
    task automatic run_frames(input logic [CFG_DATA_W-1:0] width_data,
                              input logic [CFG_DATA_W-1:0] height_data,
                              input int unsigned frames);
        logic [OUT_W_W-1:0] w_field;
        logic [OUT_H_W-1:0] h_field;
        int unsigned        eff_w, eff_h, total;
        write_reg(CFG_OUT_WIDTH, width_data);
        write_reg(CFG_OUT_HEIGHT, height_data);
        cfg_we  <= 1'b0;
        w_field = width_data[OUT_W_W-1:0];
        h_field = height_data[OUT_H_W-1:0];
        eff_w   = (w_field == 0) ? 1 :
                  (w_field > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : int'(w_field);
        eff_h   = (h_field == 0) ? 1 :
                  (h_field > MAX_OUT_HEIGHT) ? MAX_OUT_HEIGHT : int'(h_field);
        total   = frames * FACTOR * FACTOR * eff_w * eff_h;
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        repeat (total) begin
            send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                       ($urandom_range(0, 63) == 0) || (items_sent == pause_mark));
        end
        settle();
    endtask

    // main sequence
    initial begin
        int unsigned random_end;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_OUT_WIDTH;
        cfg_data        = '0;
        pix_in.valid    = 1'b0;
        pix_in.in_red   = '0;
        pix_in.in_green = '0;
        pix_in.in_blue  = '0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        items_sent      = 0;
        pause_mark      = '1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry is one block: red all low, green all high, blue half high
        for (int k = 0; k < FACTOR * FACTOR; k++) begin
            send_pixel(8'h00, 8'hFF, (k % 2 == 1) ? 8'hFF : 8'h00, 1'b0);
        end
        settle();

        // zero sizes clamp to one, upper data bits of the width are dropped
        run_frames(11'h600, 11'h000, 1);

        // random small geometries with occasional zero sizes
        pause_mark = items_sent + 37;
        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end) begin
            run_frames(($urandom_range(0, 7) == 0) ? 11'd0 : CFG_DATA_W'($urandom_range(1, 6)),
                       ($urandom_range(0, 7) == 0) ? 11'd0 : CFG_DATA_W'($urandom_range(1, 3)),
                       $urandom_range(1, 2));
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
